>>> hw/rtl/lofs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lofs_pkg: shared types and constants for the frame sync block
// Register indexes, field widths and the header fill count type.
// ----------------------------------------------------------------------------
package lofs_pkg;

   localparam int unsigned NumOpcodes     = 5;
   localparam int unsigned CsrIndexWidth  = 3;
   localparam int unsigned CsrDataWidth   = 8;
   localparam logic [15:0] MinFrameLength = 16'd3;

   typedef logic [CsrIndexWidth-1:0] csr_index_type;
   typedef logic [CsrDataWidth-1:0]  csr_data_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_OPCODE_A    = 3'd0,
      CSR_OPCODE_B    = 3'd1,
      CSR_OPCODE_C    = 3'd2,
      CSR_OPCODE_D    = 3'd3,
      CSR_OPCODE_E    = 3'd4,
      CSR_ENABLE_MASK = 3'd5
   } csr_reg_type;

   // header bytes held between steps: 0..2
   typedef logic [1:0] fill_type;

   localparam fill_type FillEmpty = 2'd0;
   localparam fill_type FillOne   = 2'd1;
   localparam fill_type FillTwo   = 2'd2;

endpackage

>>> hw/rtl/lofs_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lofs_req_if: received byte channel
// Valid/ready channel carrying one serial byte per request.
// ----------------------------------------------------------------------------
interface lofs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> hw/rtl/lofs_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lofs_rsp_if: payload byte channel
// Valid/ready channel carrying one tagged payload byte per request.
// ----------------------------------------------------------------------------
interface lofs_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  payload_byte;
   logic [7:0]  frame_opcode;
   logic [15:0] frame_length;
   logic        last_in_frame;

   modport source (output valid, output payload_byte, output frame_opcode,
                   output frame_length, output last_in_frame, input ready);
   modport sink   (input valid, input payload_byte, input frame_opcode,
                   input frame_length, input last_in_frame, output ready);
endinterface

>>> hw/rtl/length_opcode_frame_sync_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_opcode_frame_sync_top: length-prefixed frame synchronizer
// Hunts for a 3-byte header (LE length, opcode) and streams the payload.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake       contents
//  req_if    in   valid/ready     rx_byte
//  rsp_if    out  valid/ready     payload_byte, frame_opcode, frame_length,
//                                 last_in_frame
//  csr_*     in   csr_we only     csr_index (0..5), csr_wdata
//
//  Cycles: one request per clock unless stalled. The header check and payload
//  counter are a single level of logic between the state registers and the
//  output register, so a byte is taken every cycle unless stalled and its result
//  (if any) is registered in the next cycle.
//  Reset: synchronous, clears the window, fill, frame state, registers and
//  the output valid.
//  Stalls: req_if.ready drops only while a result sits in the output
//  register and rsp_if.ready is low.
//
module length_opcode_frame_sync_top (
   input  logic                   clock,
   input  logic                   reset,
   lofs_req_if.sink               req_if,
   lofs_rsp_if.source             rsp_if,
   input  logic                   csr_we,
   input  lofs_pkg::csr_index_type csr_index,
   input  lofs_pkg::csr_data_type  csr_wdata
);
   import lofs_pkg::*;

   // configuration
   logic [7:0]            opcode_ff [NumOpcodes];
   logic [NumOpcodes-1:0] enable_ff;

   // hunting / frame state
   logic [7:0]  win0_ff, win0_in;
   logic [7:0]  win1_ff, win1_in;
   fill_type    fill_ff, fill_in;
   logic        in_payload_ff, in_payload_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [7:0]  held_op_ff, held_op_in;
   logic [15:0] held_len_ff, held_len_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic [7:0]  rsp_op_ff, rsp_op_in;
   logic [15:0] rsp_len_ff, rsp_len_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        req_fire;
   logic        op_match;
   logic        is_last;
   logic [15:0] hdr_len;

   // output register frees up in the same cycle it is taken
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_fire     = req_if.valid && req_if.ready;

   assign hdr_len = {win1_ff, win0_ff};
   assign is_last = (remaining_ff <= 16'd1);

   always_comb begin
      op_match = 1'b0;
      for (int i = 0; i < NumOpcodes; i++) begin
         if (enable_ff[i] && (opcode_ff[i] == req_if.rx_byte)) begin
            op_match = 1'b1;
         end
      end
   end

   always_comb begin
      win0_in       = win0_ff;
      win1_in       = win1_ff;
      fill_in       = fill_ff;
      in_payload_in = in_payload_ff;
      remaining_in  = remaining_ff;
      held_op_in    = held_op_ff;
      held_len_in   = held_len_ff;
      if (req_fire) begin
         if (in_payload_ff) begin
            if (is_last) begin
               remaining_in  = 16'd0;
               in_payload_in = 1'b0;
               fill_in       = FillEmpty;
            end else begin
               remaining_in = remaining_ff - 16'd1;
            end
         end else begin
            case (fill_ff)
               FillEmpty: begin
                  win0_in = req_if.rx_byte;
                  fill_in = FillOne;
               end
               FillOne: begin
                  win1_in = req_if.rx_byte;
                  fill_in = FillTwo;
               end
               default: begin
                  // third byte completes the header; opcode is the new byte
                  if ((hdr_len >= MinFrameLength) && op_match) begin
                     in_payload_in = 1'b1;
                     held_op_in    = req_if.rx_byte;
                     held_len_in   = hdr_len;
                     remaining_in  = hdr_len - 16'd1;
                     fill_in       = FillEmpty;
                  end else begin
                     // reject (bad opcode or short length): slide by one
                     win0_in = win1_ff;
                     win1_in = req_if.rx_byte;
                     fill_in = FillTwo;
                  end
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_op_in    = rsp_op_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_last_in  = rsp_last_ff;
      if (req_fire && in_payload_ff) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = req_if.rx_byte;
         rsp_op_in    = held_op_ff;
         rsp_len_in   = held_len_ff;
         rsp_last_in  = is_last;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumOpcodes; i++) begin
            opcode_ff[i] <= 8'd0;
         end
         enable_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OPCODE_A:    opcode_ff[0] <= csr_wdata;
            CSR_OPCODE_B:    opcode_ff[1] <= csr_wdata;
            CSR_OPCODE_C:    opcode_ff[2] <= csr_wdata;
            CSR_OPCODE_D:    opcode_ff[3] <= csr_wdata;
            CSR_OPCODE_E:    opcode_ff[4] <= csr_wdata;
            CSR_ENABLE_MASK: enable_ff    <= csr_wdata[NumOpcodes-1:0];
            default: begin
               // unknown index: ignored
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win0_ff       <= 8'd0;
         win1_ff       <= 8'd0;
         fill_ff       <= FillEmpty;
         in_payload_ff <= 1'b0;
         remaining_ff  <= 16'd0;
         held_op_ff    <= 8'd0;
         held_len_ff   <= 16'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         win0_ff       <= win0_in;
         win1_ff       <= win1_in;
         fill_ff       <= fill_in;
         in_payload_ff <= in_payload_in;
         remaining_ff  <= remaining_in;
         held_op_ff    <= held_op_in;
         held_len_ff   <= held_len_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload only, no reset needed
   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_op_ff   <= rsp_op_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.payload_byte  = rsp_byte_ff;
   assign rsp_if.frame_opcode  = rsp_op_ff;
   assign rsp_if.frame_length  = rsp_len_ff;
   assign rsp_if.last_in_frame = rsp_last_ff;

   // payload byte taken -> result registered next cycle
   a_payload_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_fire && in_payload_ff) |=> rsp_valid_ff)
      else $error("payload byte produced no result");

   // header bytes never produce a result
   a_header_silent: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !in_payload_ff) |=> !rsp_valid_ff)
      else $error("header byte produced a result");

   // last payload byte returns to hunting with an empty window
   a_last_exits: assert property (@(posedge clock) disable iff (reset)
      (req_fire && in_payload_ff && is_last) |=>
         (!in_payload_ff && (fill_ff == FillEmpty) && rsp_last_ff))
      else $error("frame end not handled");

   // counter is live exactly while in a frame
   a_remaining_consistent: assert property (@(posedge clock) disable iff (reset)
      in_payload_ff == (remaining_ff != 16'd0))
      else $error("remaining count out of step with frame state");

endmodule
